// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CHK_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define CHK_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wrms_pkg.sv =====
`timescale 1ns / 1ps
package wrms_pkg;

   localparam int SAMPLE_W = 12;
   localparam int RMS_W    = 12;
   localparam int P2P_W    = 12;
   localparam int COUNT_W  = 9;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_of_window;
   } req_type;

   typedef struct packed {
      logic [RMS_W-1:0]   rms_level;
      logic [P2P_W-1:0]   swing;
      logic [COUNT_W-1:0] sample_count;
   } rsp_type;

   // take: an item enters the accumulator; clear: window results are out, restart
   typedef struct packed {
      logic take;
      logic clear;
   } acc_ctl_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FOLD,
      ST_DIVIDE,
      ST_ROOT,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/wrms_acc.sv =====
`timescale 1ns / 1ps
module wrms_acc import wrms_pkg::*; #(
   parameter int SAMPLE_BITS = 12,
   parameter int WINDOW_MAX  = 256
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  acc_ctl_type                                   ctl,
   input  logic [SAMPLE_BITS-1:0]                        sample_in,
   input  logic                                          last_in,
   output logic                                          close,
   output logic [2*SAMPLE_BITS+$clog2(WINDOW_MAX+1)-1:0] sum_total,
   output logic [$clog2(WINDOW_MAX+1)-1:0]               count,
   output logic [SAMPLE_BITS-1:0]                        min_value,
   output logic [SAMPLE_BITS-1:0]                        max_value
);

   localparam int CntW = $clog2(WINDOW_MAX + 1);
   localparam int SqW  = 2 * SAMPLE_BITS;
   localparam int SumW = SqW + CntW;

   logic [SqW-1:0]         sq_ff, sq_in;
   logic                   pend_ff, pend_in;
   logic [SumW-1:0]        sum_ff, sum_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SqW-1:0]         s_ext;
   logic [CntW-1:0]        count_inc;

   always_comb begin
      s_ext     = SqW'(sample_in);
      count_inc = CntW'(count_ff + CntW'(1));
      close     = last_in || (count_inc == CntW'(WINDOW_MAX));
      // square is registered in sq_ff after the item is taken; fold it in here
      sum_total = pend_ff ? SumW'(sum_ff + SumW'(sq_ff)) : sum_ff;
      count     = count_ff;
      min_value = min_ff;
      max_value = max_ff;
   end

   always_comb begin
      sq_in    = sq_ff;
      pend_in  = 1'b0;
      sum_in   = sum_total;
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (ctl.clear) begin
         sum_in   = '0;
         count_in = '0;
         min_in   = '1;
         max_in   = '0;
      end else if (ctl.take) begin
         sq_in    = s_ext * s_ext;
         pend_in  = 1'b1;
         count_in = count_inc;
         if (sample_in < min_ff) begin
            min_in = sample_in;
         end
         if (sample_in > max_ff) begin
            max_in = sample_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
      end else begin
         pend_ff  <= pend_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

endmodule

// ===== rtl/wrms_div.sv =====
`timescale 1ns / 1ps
module wrms_div #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int StepW = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepW-1:0]      step_ff, step_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    rem_t;
   logic [DIVISOR_W:0]    diff;
   logic                  q_bit;

   // restoring division: one quotient bit per cycle, shifted into the dividend register
   always_comb begin
      rem_t = {rem_ff, dq_ff[DIVIDEND_W-1]};
      diff  = rem_t - {1'b0, dvs_ff};
      q_bit = rem_t >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(DIVIDEND_W - 1);
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DIVIDEND_W-2:0], q_bit};
         rem_in = q_bit ? diff[DIVISOR_W-1:0] : rem_t[DIVISOR_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - StepW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ===== rtl/wrms_sqrt.sv =====
`timescale 1ns / 1ps
module wrms_sqrt #(
   parameter int ROOT_W = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   localparam int RadW  = 2 * ROOT_W;
   localparam int StepW = $clog2(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [RadW-1:0]   rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+1:0] rem_t;
   logic [ROOT_W+1:0] trial;
   logic [ROOT_W+1:0] diff;
   logic              r_bit;

   // one root bit per cycle from the top two radicand bits
   always_comb begin
      rem_t = {rem_ff[ROOT_W-1:0], rad_ff[RadW-1 -: 2]};
      trial = {root_ff, 2'b01};
      diff  = rem_t - trial;
      r_bit = rem_t >= trial;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(ROOT_W - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RadW-3:0], 2'b00};
         rem_in  = r_bit ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
         root_in = {root_ff[ROOT_W-2:0], r_bit};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - StepW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/window_rms_and_peak_to_peak_unit.sv =====
`timescale 1ns / 1ps
// Windowed RMS and peak-to-peak meter.
// req channel: one converter sample per item with a last_of_window flag. While a
// window is open, req_stall stays low and an item is taken every cycle that
// req_valid is high; a square is formed and added into an exact sum while count,
// minimum and maximum update. A window closes on last_of_window or when it holds
// WINDOW_MAX samples. After the closing item req_stall rises while a bit-serial
// divider forms sum / count (one quotient bit per cycle) and a bit-serial square
// root is then taken of the quotient.
// rsp channel: one item per window with rms_level, swing, sample_count;
// it is loaded once the divider and then the root unit are done. The result sits
// in an output register: the next window is taken while it waits. If rsp_stall
// holds that register when a second window closes, req_stall stays high until
// the first result is taken.
// Reset (synchronous) empties the window and drops any pending result.
module window_rms_and_peak_to_peak_unit import wrms_pkg::*; #(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CntW = $clog2(WINDOW_MAX + 1);
   localparam int SumW = 2 * SAMPLE_BITS + CntW;

   state_type              state_ff, state_in;
   acc_ctl_type            acc_ctl;
   logic [SAMPLE_BITS-1:0] sample_in;
   logic                   close;
   logic [SumW-1:0]        sum_total;
   logic [CntW-1:0]        count;
   logic [SAMPLE_BITS-1:0] min_value;
   logic [SAMPLE_BITS-1:0] max_value;
   logic                   div_start;
   logic                   div_done;
   logic [SumW-1:0]        quotient;
   logic                   root_start;
   logic                   root_done;
   logic [SAMPLE_BITS-1:0] root;
   logic                   out_free;
   logic                   load;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   assign sample_in = SAMPLE_BITS'(req_data.sample);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   wrms_acc #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_MAX  (WINDOW_MAX)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (acc_ctl),
      .sample_in (sample_in),
      .last_in   (req_data.last_of_window),
      .close     (close),
      .sum_total (sum_total),
      .count     (count),
      .min_value (min_value),
      .max_value (max_value)
   );

   wrms_div #(
      .DIVIDEND_W (SumW),
      .DIVISOR_W  (CntW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_total),
      .divisor  (count),
      .done     (div_done),
      .quotient (quotient)
   );

   wrms_sqrt #(
      .ROOT_W (SAMPLE_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ((2*SAMPLE_BITS)'(quotient)),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (acc_ctl.take && close) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      div_start     = 1'b0;
      root_start    = 1'b0;
      load          = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_stall = 1'b0;
         end
         ST_FOLD: begin
            div_start = 1'b1;
         end
         ST_DIVIDE: begin
            root_start = div_done;
         end
         ST_ROOT: begin
            load = 1'b0;
         end
         ST_EMIT: begin
            load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      acc_ctl.take  = req_valid && !req_stall;
      acc_ctl.clear = load;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.rms_level    = RMS_W'(root);
         rsp_data_in.swing        = P2P_W'(max_value - min_value);
         rsp_data_in.sample_count = COUNT_W'(count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/wrms_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wrms_chk import wrms_pkg::*; #(
   parameter int WINDOW_MAX = 256
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data);
   endproperty

   // an item with last_of_window set must hold off the next one while the result is formed
   property p_close_stalls;
      req_valid && !req_stall && req_data.last_of_window |=> req_stall;
   endproperty

   property p_count_range;
      rsp_valid |-> (WINDOW_MAX > 511) ||
         (rsp_data.sample_count != 0 && rsp_data.sample_count <= WINDOW_MAX);
   endproperty

   // a single-sample window has no spread
   property p_single_span;
      rsp_valid && rsp_data.sample_count == 1 |-> (WINDOW_MAX > 511) || rsp_data.swing == 0;
   endproperty

   property p_reset_empty;
      !reset && $past(reset) |-> !rsp_valid;
   endproperty

   `CHK_ASSERT_RST(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result item changed")
   `CHK_ASSERT_RST(a_close_stalls, clock, reset, p_close_stalls, "item after window close")
   `CHK_ASSERT_RST(a_count_range, clock, reset, p_count_range, "sample count out of range")
   `CHK_ASSERT_RST(a_single_span, clock, reset, p_single_span, "spread on one-sample window")
   `CHK_ASSERT(a_reset_empty, clock, p_reset_empty, "result item present after reset")

endmodule

bind window_rms_and_peak_to_peak_unit wrms_chk #(
   .WINDOW_MAX (WINDOW_MAX)
) u_wrms_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
